// ===== sv/wcsa_pkg.sv =====
// Shared widths, codes and types of the weighted chi-square accumulator.
package wcsa_pkg;

   // Histogram and result sizes.
   localparam int MAX_BINS  = 4096;
   localparam int CNT_W     = 13;
   localparam int COUNT_CAP = (MAX_BINS < 8191) ? MAX_BINS : 8191;
   localparam int SUM_W     = 48;

   // Field and register widths.
   localparam int FIELD_W   = 32;
   localparam int REG_W     = 21;
   localparam int CSR_IDX_W = 2;
   localparam int IN_W      = 8 * FIELD_W;
   localparam int OUT_W     = 64;

   // Signed Q4.16 one (the 21-bit registers), and the rounding step of the Q.16 products.
   localparam int ONE_Q16   = 65536;
   localparam int RND_SH    = 16;
   localparam int HALF_LSB  = 1 << (RND_SH - 1);

   // Intermediate widths of the datapath.
   localparam int W0_W      = REG_W + 2;
   localparam int C_W       = 27;
   localparam int CR_W      = C_W + RND_SH;
   localparam int S_W       = 43;
   localparam int SR_W      = S_W + RND_SH;
   localparam int MSUM_W    = 62;
   localparam int MODEL_W   = MSUM_W - RND_SH;
   localparam int DIFF_W    = MODEL_W + 1;
   localparam int DEN_W     = 88;
   localparam int NUM_W     = 94;
   localparam int QUO_W     = SUM_W;
   localparam int QCNT_W    = $clog2(QUO_W);

   // Digit-serial multiplier: 47-bit multiplicand, 16-bit digits, three digits.
   localparam int MC_W      = 47;
   localparam int DIG_W     = 16;
   localparam int NDIG      = 3;
   localparam int MP_W      = DIG_W * NDIG;
   localparam int MACT_W    = MC_W + DIG_W;
   localparam int LOW_W     = DIG_W * (NDIG - 1);
   localparam int PROD_W    = MACT_W + LOW_W;
   localparam int DIG_CNT_W = $clog2(NDIG);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALE   = 2'd0,
      CSR_WEIGHT2 = 2'd1,
      CSR_WEIGHT4 = 2'd2
   } csr_index_type;

   localparam logic signed [REG_W-1:0] SCALE_RESET   = 21'sd32768;
   localparam logic signed [REG_W-1:0] WEIGHT2_RESET = 21'sd32768;
   localparam logic signed [REG_W-1:0] WEIGHT4_RESET = 21'sd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_POST,
      ST_CHECK,
      ST_DIV,
      ST_FINISH
   } state_type;

   // Multiply steps of one kept bin, in the order the sequencer runs them.
   typedef enum logic [3:0] {
      OP_C0,
      OP_C2,
      OP_C4,
      OP_ERR_SQ,
      OP_MODEL0,
      OP_MODEL2,
      OP_MODEL4,
      OP_SIG0,
      OP_SIG2,
      OP_SIG4,
      OP_DEN0,
      OP_DEN2,
      OP_DEN4,
      OP_NUM
   } op_type;

   typedef struct packed {
      logic req_ready;
      logic mac_en;
      logic chk_en;
      logic div_en;
      logic fin_en;
   } ctl_type;

endpackage

// ===== sv/weighted_chi_square_accumulator.sv =====
// Weighted chi-square accumulator: digit-serial multiplier, bit-serial divider, pass totals.
//
//   channel   direction  handshake                 payload
//   req       in         req_tvalid / req_tready   req_tdata (8 x 32 bits), req_tlast
//   rsp       out        rsp_tvalid / rsp_tready   rsp_tdata (chi_square, points_used), rsp_tuser
//   csr       in         csr_valid / csr_ready     csr_index, csr_wdata
//
// A kept bin is accepted, runs 14 products of three digits each through the 47x16
// multiplier, settles its numerator in ST_POST and ST_CHECK, passes the restoring
// divider, which gives one quotient bit a cycle, and is then accumulated. A kept bin
// whose quotient needs more than 48 bits skips the divider; a skipped bin goes to ST_FINISH.
// Reset clears the pass totals; no memory needs clearing.
// The result waits in its own register while the next bins are taken; only a further
// last bin waits for it to be taken. Register writes are accepted in every cycle.
module weighted_chi_square_accumulator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // data_value, data_uncertainty, template_zero, template_two, template_four,
   // template_zero_err, template_two_err, template_four_err (32 bits each)
   input  logic [wcsa_pkg::IN_W-1:0]         req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // chi_square [47:0], points_used [60:48], zero fill [63:61]
   output logic [wcsa_pkg::OUT_W-1:0]        rsp_tdata,
   // saturated
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wcsa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wcsa_pkg::REG_W-1:0]        csr_wdata
);

   localparam int FW = wcsa_pkg::FIELD_W;

   wcsa_pkg::state_type state_ff, state_in;
   wcsa_pkg::ctl_type   ctl;
   wcsa_pkg::op_type    op_ff;

   logic signed [wcsa_pkg::REG_W-1:0]  scale_ff, w2_ff, w4_ff;

   // Latched bin.
   logic signed [FW-1:0] content_ff;
   logic [FW-1:0]        err_ff;
   logic [FW-1:0]        z0_ff, z2_ff, z4_ff, e0_ff, e2_ff, e4_ff;
   logic                 keep_ff, last_ff;

   // Per-bin intermediates.
   logic [wcsa_pkg::C_W-1:0]    c0_mag_ff, c2_mag_ff, c4_mag_ff;
   logic                        c0_neg_ff, c2_neg_ff, c4_neg_ff;
   logic [wcsa_pkg::S_W-1:0]    s0_ff, s2_ff, s4_ff;
   logic [wcsa_pkg::MSUM_W-1:0] model_sum_ff;
   logic signed [wcsa_pkg::MODEL_W-1:0] model_ff;
   logic signed [wcsa_pkg::DIFF_W-1:0]  diff_ff;
   logic [wcsa_pkg::MC_W-1:0]   ad_ff;
   logic [wcsa_pkg::DEN_W-1:0]  den_ff;
   logic [wcsa_pkg::NUM_W-1:0]  num_ff;

   // Multiplier.
   logic [wcsa_pkg::DIG_CNT_W-1:0]        dig_ff;
   logic [wcsa_pkg::MC_W-1:0]             acc_ff;
   logic [wcsa_pkg::LOW_W-1:0]            low_ff;
   logic [wcsa_pkg::MP_W-wcsa_pkg::DIG_W-1:0] mp_ff;
   logic [wcsa_pkg::PROD_W-1:0]           prod_ff;
   logic                                  prod_neg_ff;
   logic                                  pend_ff;
   wcsa_pkg::op_type                      pend_op_ff;

   // Divider.
   logic [wcsa_pkg::DEN_W-1:0]  rem_ff;
   logic [wcsa_pkg::QUO_W-1:0]  nbits_ff;
   logic [wcsa_pkg::QUO_W-1:0]  q_ff;
   logic [wcsa_pkg::QCNT_W-1:0] div_cnt_ff;
   logic                        big_ff;

   // Pass totals and result register.
   logic [wcsa_pkg::SUM_W-1:0]  sum_ff;
   logic [wcsa_pkg::CNT_W-1:0]  cnt_ff;
   logic                        ovf_ff;
   logic                        rsp_valid_ff;
   logic [wcsa_pkg::SUM_W-1:0]  rsp_sum_ff;
   logic [wcsa_pkg::CNT_W-1:0]  rsp_cnt_ff;
   logic                        rsp_sat_ff;

   // ---------------------------------------------------------------- combinational
   logic                            in_keep;
   logic signed [wcsa_pkg::W0_W-1:0] w0;
   logic [wcsa_pkg::W0_W-1:0]       w0_mag;
   logic [wcsa_pkg::REG_W-1:0]      scale_mag, w2_mag, w4_mag;
   logic [FW-1:0]                   z0_mag, z2_mag, z4_mag;
   logic [wcsa_pkg::MC_W-1:0]       mcand_sel;
   logic [wcsa_pkg::MP_W-1:0]       mplier_sel;
   logic                            op_neg;
   logic [wcsa_pkg::DIG_W-1:0]      digit;
   logic [wcsa_pkg::MACT_W-1:0]     mac_base, mac_prod, mac_t;
   logic                            mul_last;
   logic [wcsa_pkg::CR_W-1:0]       c_rnd;
   logic [wcsa_pkg::SR_W-1:0]       s_rnd;
   logic [wcsa_pkg::MSUM_W-1:0]     p_model, model_rnd;
   logic [wcsa_pkg::DEN_W:0]        rem_sh;
   logic                            rem_ge;
   logic                            chk_big;
   logic [wcsa_pkg::SUM_W:0]        sum_add;
   logic                            ovf_now;
   logic [wcsa_pkg::SUM_W-1:0]      sum_new;
   logic [wcsa_pkg::CNT_W-1:0]      cnt_new;
   logic                            ovf_new;

   assign in_keep = !req_tdata[FW-1] && (|req_tdata[FW-2:0])
                    && !req_tdata[2*FW-1] && (|req_tdata[2*FW-2:FW]);

   assign w0 = wcsa_pkg::W0_W'(wcsa_pkg::ONE_Q16) - wcsa_pkg::W0_W'(w2_ff)
               - wcsa_pkg::W0_W'(w4_ff);
   assign w0_mag    = w0[wcsa_pkg::W0_W-1] ? wcsa_pkg::W0_W'(-w0) : wcsa_pkg::W0_W'(w0);
   assign scale_mag = scale_ff[wcsa_pkg::REG_W-1] ? wcsa_pkg::REG_W'(-scale_ff)
                                                  : wcsa_pkg::REG_W'(scale_ff);
   assign w2_mag    = w2_ff[wcsa_pkg::REG_W-1] ? wcsa_pkg::REG_W'(-w2_ff)
                                               : wcsa_pkg::REG_W'(w2_ff);
   assign w4_mag    = w4_ff[wcsa_pkg::REG_W-1] ? wcsa_pkg::REG_W'(-w4_ff)
                                               : wcsa_pkg::REG_W'(w4_ff);
   assign z0_mag = z0_ff[FW-1] ? FW'(-z0_ff) : z0_ff;
   assign z2_mag = z2_ff[FW-1] ? FW'(-z2_ff) : z2_ff;
   assign z4_mag = z4_ff[FW-1] ? FW'(-z4_ff) : z4_ff;

   // Operands of the multiplier for the current step; all products run on magnitudes.
   always_comb begin
      mcand_sel  = '0;
      mplier_sel = '0;
      op_neg     = 1'b0;
      case (op_ff)
         wcsa_pkg::OP_C0: begin
            mcand_sel  = wcsa_pkg::MC_W'(w0_mag);
            mplier_sel = wcsa_pkg::MP_W'(scale_mag);
            op_neg     = scale_ff[wcsa_pkg::REG_W-1] ^ w0[wcsa_pkg::W0_W-1];
         end
         wcsa_pkg::OP_C2: begin
            mcand_sel  = wcsa_pkg::MC_W'(w2_mag);
            mplier_sel = wcsa_pkg::MP_W'(scale_mag);
            op_neg     = scale_ff[wcsa_pkg::REG_W-1] ^ w2_ff[wcsa_pkg::REG_W-1];
         end
         wcsa_pkg::OP_C4: begin
            mcand_sel  = wcsa_pkg::MC_W'(w4_mag);
            mplier_sel = wcsa_pkg::MP_W'(scale_mag);
            op_neg     = scale_ff[wcsa_pkg::REG_W-1] ^ w4_ff[wcsa_pkg::REG_W-1];
         end
         wcsa_pkg::OP_ERR_SQ: begin
            mcand_sel  = wcsa_pkg::MC_W'(err_ff);
            mplier_sel = wcsa_pkg::MP_W'(err_ff);
         end
         wcsa_pkg::OP_MODEL0: begin
            mcand_sel  = wcsa_pkg::MC_W'(c0_mag_ff);
            mplier_sel = wcsa_pkg::MP_W'(z0_mag);
            op_neg     = c0_neg_ff ^ z0_ff[FW-1];
         end
         wcsa_pkg::OP_MODEL2: begin
            mcand_sel  = wcsa_pkg::MC_W'(c2_mag_ff);
            mplier_sel = wcsa_pkg::MP_W'(z2_mag);
            op_neg     = c2_neg_ff ^ z2_ff[FW-1];
         end
         wcsa_pkg::OP_MODEL4: begin
            mcand_sel  = wcsa_pkg::MC_W'(c4_mag_ff);
            mplier_sel = wcsa_pkg::MP_W'(z4_mag);
            op_neg     = c4_neg_ff ^ z4_ff[FW-1];
         end
         wcsa_pkg::OP_SIG0: begin
            mcand_sel  = wcsa_pkg::MC_W'(c0_mag_ff);
            mplier_sel = wcsa_pkg::MP_W'(e0_ff);
         end
         wcsa_pkg::OP_SIG2: begin
            mcand_sel  = wcsa_pkg::MC_W'(c2_mag_ff);
            mplier_sel = wcsa_pkg::MP_W'(e2_ff);
         end
         wcsa_pkg::OP_SIG4: begin
            mcand_sel  = wcsa_pkg::MC_W'(c4_mag_ff);
            mplier_sel = wcsa_pkg::MP_W'(e4_ff);
         end
         wcsa_pkg::OP_DEN0: begin
            mcand_sel  = wcsa_pkg::MC_W'(s0_ff);
            mplier_sel = wcsa_pkg::MP_W'(s0_ff);
         end
         wcsa_pkg::OP_DEN2: begin
            mcand_sel  = wcsa_pkg::MC_W'(s2_ff);
            mplier_sel = wcsa_pkg::MP_W'(s2_ff);
         end
         wcsa_pkg::OP_DEN4: begin
            mcand_sel  = wcsa_pkg::MC_W'(s4_ff);
            mplier_sel = wcsa_pkg::MP_W'(s4_ff);
         end
         wcsa_pkg::OP_NUM: begin
            mcand_sel  = ad_ff;
            mplier_sel = wcsa_pkg::MP_W'(ad_ff);
         end
         default: begin
            mcand_sel  = '0;
            mplier_sel = '0;
         end
      endcase
   end

   // Least significant digit first; the low digits of the product shift out into low_ff.
   assign digit    = (dig_ff == '0) ? mplier_sel[wcsa_pkg::DIG_W-1:0]
                                    : mp_ff[wcsa_pkg::DIG_W-1:0];
   assign mac_base = (dig_ff == '0) ? '0 : wcsa_pkg::MACT_W'(acc_ff);
   assign mac_prod = wcsa_pkg::MACT_W'(mcand_sel) * wcsa_pkg::MACT_W'(digit);
   assign mac_t    = mac_base + mac_prod;
   assign mul_last = (dig_ff == wcsa_pkg::DIG_CNT_W'(wcsa_pkg::NDIG - 1));

   // Round to nearest, ties up. A negative c keeps its magnitude, rounded with one less.
   assign c_rnd = prod_ff[wcsa_pkg::CR_W-1:0] + wcsa_pkg::CR_W'(wcsa_pkg::HALF_LSB)
                  - wcsa_pkg::CR_W'(prod_neg_ff);
   assign s_rnd = prod_ff[wcsa_pkg::SR_W-1:0] + wcsa_pkg::SR_W'(wcsa_pkg::HALF_LSB);
   assign p_model   = prod_ff[wcsa_pkg::MSUM_W-1:0];
   assign model_rnd = model_sum_ff + wcsa_pkg::MSUM_W'(wcsa_pkg::HALF_LSB);

   // The quotient has more than 48 bits exactly when num / 2^32 reaches the denominator.
   assign chk_big = (wcsa_pkg::DEN_W'(num_ff[wcsa_pkg::NUM_W-1:32]) >= den_ff);
   assign rem_sh  = {rem_ff, nbits_ff[wcsa_pkg::QUO_W-1]};
   assign rem_ge  = (rem_sh >= {1'b0, den_ff});

   assign sum_add = {1'b0, sum_ff} + {1'b0, q_ff};
   assign ovf_now = big_ff || sum_add[wcsa_pkg::SUM_W];

   always_comb begin
      sum_new = sum_ff;
      cnt_new = cnt_ff;
      ovf_new = ovf_ff;
      if (keep_ff) begin
         sum_new = ovf_now ? '1 : sum_add[wcsa_pkg::SUM_W-1:0];
         ovf_new = ovf_ff || ovf_now;
         if (cnt_ff < wcsa_pkg::CNT_W'(wcsa_pkg::COUNT_CAP)) begin
            cnt_new = cnt_ff + wcsa_pkg::CNT_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wcsa_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = in_keep ? wcsa_pkg::ST_MUL : wcsa_pkg::ST_FINISH;
            end
         end
         wcsa_pkg::ST_MUL: begin
            if (mul_last && op_ff == wcsa_pkg::OP_NUM) begin
               state_in = wcsa_pkg::ST_POST;
            end
         end
         wcsa_pkg::ST_POST:  state_in = wcsa_pkg::ST_CHECK;
         wcsa_pkg::ST_CHECK: state_in = chk_big ? wcsa_pkg::ST_FINISH : wcsa_pkg::ST_DIV;
         wcsa_pkg::ST_DIV: begin
            if (div_cnt_ff == wcsa_pkg::QCNT_W'(wcsa_pkg::QUO_W - 1)) begin
               state_in = wcsa_pkg::ST_FINISH;
            end
         end
         wcsa_pkg::ST_FINISH: begin
            if (!(last_ff && rsp_valid_ff && !rsp_tready)) begin
               state_in = wcsa_pkg::ST_IDLE;
            end
         end
         default: state_in = wcsa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      case (state_ff)
         wcsa_pkg::ST_IDLE:   ctl.req_ready = 1'b1;
         wcsa_pkg::ST_MUL:    ctl.mac_en    = 1'b1;
         wcsa_pkg::ST_POST:   ctl           = '0;
         wcsa_pkg::ST_CHECK:  ctl.chk_en    = 1'b1;
         wcsa_pkg::ST_DIV:    ctl.div_en    = 1'b1;
         wcsa_pkg::ST_FINISH: ctl.fin_en    = !(last_ff && rsp_valid_ff && !rsp_tready);
         default:             ctl           = '0;
      endcase
   end

   assign req_tready = ctl.req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(wcsa_pkg::OUT_W - wcsa_pkg::CNT_W - wcsa_pkg::SUM_W){1'b0}},
                        rsp_cnt_ff, rsp_sum_ff};
   assign rsp_tuser  = rsp_sat_ff;

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wcsa_pkg::ST_IDLE;
         scale_ff     <= wcsa_pkg::SCALE_RESET;
         w2_ff        <= wcsa_pkg::WEIGHT2_RESET;
         w4_ff        <= wcsa_pkg::WEIGHT4_RESET;
         op_ff        <= wcsa_pkg::OP_C0;
         dig_ff       <= '0;
         pend_ff      <= 1'b0;
         div_cnt_ff   <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (wcsa_pkg::csr_index_type'(csr_index))
               wcsa_pkg::CSR_SCALE:   scale_ff <= csr_wdata;
               wcsa_pkg::CSR_WEIGHT2: w2_ff    <= csr_wdata;
               wcsa_pkg::CSR_WEIGHT4: w4_ff    <= csr_wdata;
               default: ;
            endcase
         end
         if (ctl.req_ready && req_tvalid) begin
            op_ff  <= wcsa_pkg::OP_C0;
            dig_ff <= '0;
         end else if (ctl.mac_en) begin
            if (mul_last) begin
               dig_ff <= '0;
               if (op_ff != wcsa_pkg::OP_NUM) begin
                  op_ff <= wcsa_pkg::op_type'(op_ff + 4'd1);
               end
            end else begin
               dig_ff <= dig_ff + wcsa_pkg::DIG_CNT_W'(1);
            end
         end
         pend_ff <= ctl.mac_en && mul_last;
         if (ctl.chk_en) begin
            div_cnt_ff <= '0;
         end else if (ctl.div_en) begin
            div_cnt_ff <= div_cnt_ff + wcsa_pkg::QCNT_W'(1);
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ctl.fin_en) begin
            if (last_ff) begin
               sum_ff       <= '0;
               cnt_ff       <= '0;
               ovf_ff       <= 1'b0;
               rsp_valid_ff <= 1'b1;
            end else begin
               sum_ff <= sum_new;
               cnt_ff <= cnt_new;
               ovf_ff <= ovf_new;
            end
         end
      end
   end

   // ---------------------------------------------------------------- datapath registers
   always_ff @(posedge clock) begin
      if (ctl.req_ready && req_tvalid) begin
         content_ff   <= req_tdata[FW-1:0];
         err_ff       <= req_tdata[2*FW-1:FW];
         z0_ff        <= req_tdata[3*FW-1:2*FW];
         z2_ff        <= req_tdata[4*FW-1:3*FW];
         z4_ff        <= req_tdata[5*FW-1:4*FW];
         e0_ff        <= req_tdata[6*FW-1:5*FW];
         e2_ff        <= req_tdata[7*FW-1:6*FW];
         e4_ff        <= req_tdata[8*FW-1:7*FW];
         last_ff      <= req_tlast;
         keep_ff      <= in_keep;
         model_sum_ff <= '0;
      end

      if (ctl.mac_en) begin
         acc_ff <= mac_t[wcsa_pkg::MACT_W-1:wcsa_pkg::DIG_W];
         low_ff <= {mac_t[wcsa_pkg::DIG_W-1:0], low_ff[wcsa_pkg::LOW_W-1:wcsa_pkg::DIG_W]};
         mp_ff  <= (dig_ff == '0)
                   ? mplier_sel[wcsa_pkg::MP_W-1:wcsa_pkg::DIG_W]
                   : {{wcsa_pkg::DIG_W{1'b0}},
                      mp_ff[wcsa_pkg::MP_W-wcsa_pkg::DIG_W-1:wcsa_pkg::DIG_W]};
         if (mul_last) begin
            prod_ff     <= {mac_t, low_ff};
            prod_neg_ff <= op_neg;
            pend_op_ff  <= op_ff;
         end
      end

      // A finished product is put away while the next one runs its first digit.
      if (pend_ff) begin
         case (pend_op_ff)
            wcsa_pkg::OP_C0: begin
               c0_mag_ff <= c_rnd[wcsa_pkg::CR_W-1:wcsa_pkg::RND_SH];
               c0_neg_ff <= prod_neg_ff;
            end
            wcsa_pkg::OP_C2: begin
               c2_mag_ff <= c_rnd[wcsa_pkg::CR_W-1:wcsa_pkg::RND_SH];
               c2_neg_ff <= prod_neg_ff;
            end
            wcsa_pkg::OP_C4: begin
               c4_mag_ff <= c_rnd[wcsa_pkg::CR_W-1:wcsa_pkg::RND_SH];
               c4_neg_ff <= prod_neg_ff;
            end
            wcsa_pkg::OP_ERR_SQ: den_ff <= prod_ff[wcsa_pkg::DEN_W-1:0];
            wcsa_pkg::OP_MODEL0, wcsa_pkg::OP_MODEL2, wcsa_pkg::OP_MODEL4: begin
               model_sum_ff <= model_sum_ff + (prod_neg_ff ? ~p_model : p_model)
                               + wcsa_pkg::MSUM_W'(prod_neg_ff);
            end
            wcsa_pkg::OP_SIG0: s0_ff <= s_rnd[wcsa_pkg::SR_W-1:wcsa_pkg::RND_SH];
            wcsa_pkg::OP_SIG2: s2_ff <= s_rnd[wcsa_pkg::SR_W-1:wcsa_pkg::RND_SH];
            wcsa_pkg::OP_SIG4: s4_ff <= s_rnd[wcsa_pkg::SR_W-1:wcsa_pkg::RND_SH];
            wcsa_pkg::OP_DEN0, wcsa_pkg::OP_DEN2, wcsa_pkg::OP_DEN4: begin
               den_ff <= den_ff + prod_ff[wcsa_pkg::DEN_W-1:0];
            end
            wcsa_pkg::OP_NUM: num_ff <= prod_ff[wcsa_pkg::NUM_W-1:0];
            default: ;
         endcase
      end

      // The model settles well before the numerator step, so |content - model| runs freely.
      model_ff <= model_rnd[wcsa_pkg::MSUM_W-1:wcsa_pkg::RND_SH];
      diff_ff  <= wcsa_pkg::DIFF_W'(content_ff) - wcsa_pkg::DIFF_W'(model_ff);
      ad_ff    <= diff_ff[wcsa_pkg::DIFF_W-1] ? wcsa_pkg::MC_W'(-diff_ff)
                                              : wcsa_pkg::MC_W'(diff_ff);

      if (ctl.chk_en) begin
         rem_ff   <= wcsa_pkg::DEN_W'(num_ff[wcsa_pkg::NUM_W-1:32]);
         nbits_ff <= {num_ff[31:0], {wcsa_pkg::RND_SH{1'b0}}};
         q_ff     <= '0;
         big_ff   <= chk_big;
      end else if (ctl.div_en) begin
         rem_ff   <= rem_ge ? wcsa_pkg::DEN_W'(rem_sh - {1'b0, den_ff})
                            : rem_sh[wcsa_pkg::DEN_W-1:0];
         nbits_ff <= {nbits_ff[wcsa_pkg::QUO_W-2:0], 1'b0};
         q_ff     <= {q_ff[wcsa_pkg::QUO_W-2:0], rem_ge};
      end

      if (ctl.fin_en && last_ff) begin
         rsp_sum_ff <= sum_new;
         rsp_cnt_ff <= cnt_new;
         rsp_sat_ff <= ovf_new;
      end
   end

   // ---------------------------------------------------------------- assertions
   a_ovf_pins_sum: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (sum_ff == '1))
      else $error("saturation seen but the sum is not at full scale");

   a_cnt_capped: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= wcsa_pkg::CNT_W'(wcsa_pkg::COUNT_CAP))
      else $error("kept-bin count went past its cap");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wcsa_pkg::ST_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder reached the denominator");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wcsa_pkg::ST_DIV && div_cnt_ff == wcsa_pkg::QCNT_W'(wcsa_pkg::QUO_W - 1))
      |=> (state_ff == wcsa_pkg::ST_FINISH))
      else $error("divider did not hand over after its last quotient bit");

   a_pend_in_mul: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == wcsa_pkg::ST_MUL || state_ff == wcsa_pkg::ST_POST))
      else $error("product put away outside the multiply steps");

endmodule
